// ===== hw/rtl/jtl_pkg.sv =====
package jtl_pkg;

  // Token length counter width
  localparam int LENGTH_BITS = 16;

  // Reset value of the token capacity register
  localparam logic [15:0] MAX_LEN_RESET = 16'd256;

  // Result queue sizing (an item can push two results)
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // Token kinds
  localparam logic [3:0] KIND_NONE     = 4'd0;
  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COLON    = 4'd4;
  localparam logic [3:0] KIND_COMMA    = 4'd5;
  localparam logic [3:0] KIND_STRING   = 4'd6;
  localparam logic [3:0] KIND_INT      = 4'd7;
  localparam logic [3:0] KIND_NUMBER   = 4'd8;
  localparam logic [3:0] KIND_TRUE     = 4'd9;
  localparam logic [3:0] KIND_FALSE    = 4'd10;
  localparam logic [3:0] KIND_NULL     = 4'd11;
  localparam logic [3:0] KIND_EOF      = 4'd12;
  localparam logic [3:0] KIND_INVALID  = 4'd13;
  localparam logic [3:0] KIND_TOOLONG  = 4'd14;

  // Escape results and other character codes
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_FF  = 8'd12;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Lexer states, one-hot
  typedef enum logic [19:0] {
    ST_VALUE  = 20'b0000_0000_0000_0000_0001,
    ST_STRING = 20'b0000_0000_0000_0000_0010,
    ST_NUMBER = 20'b0000_0000_0000_0000_0100,
    ST_EXP    = 20'b0000_0000_0000_0000_1000,
    ST_EXP1   = 20'b0000_0000_0000_0001_0000,
    ST_ESCAPE = 20'b0000_0000_0000_0010_0000,
    ST_HEX1   = 20'b0000_0000_0000_0100_0000,
    ST_HEX2   = 20'b0000_0000_0000_1000_0000,
    ST_HEX3   = 20'b0000_0000_0001_0000_0000,
    ST_HEX4   = 20'b0000_0000_0010_0000_0000,
    ST_TRUE1  = 20'b0000_0000_0100_0000_0000,
    ST_TRUE2  = 20'b0000_0000_1000_0000_0000,
    ST_TRUE3  = 20'b0000_0001_0000_0000_0000,
    ST_FALSE1 = 20'b0000_0010_0000_0000_0000,
    ST_FALSE2 = 20'b0000_0100_0000_0000_0000,
    ST_FALSE3 = 20'b0000_1000_0000_0000_0000,
    ST_FALSE4 = 20'b0001_0000_0000_0000_0000,
    ST_NULL1  = 20'b0010_0000_0000_0000_0000,
    ST_NULL2  = 20'b0100_0000_0000_0000_0000,
    ST_NULL3  = 20'b1000_0000_0000_0000_0000
  } state_t;

  // One result as it sits in the output queue
  typedef struct packed {
    logic       is_token_end;
    logic [3:0] token_kind;
    logic [7:0] content_byte;
    logic       last_result;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
  endfunction

  // Characters that close a number
  function automatic logic is_term(input logic [7:0] c);
    return (c == ",") || (c == "]") || (c == "}") || is_ws(c);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (is_digit(c)) begin
      v = c - "0";
    end else if ((c >= "a") && (c <= "f")) begin
      v = c - "a" + 8'd10;
    end else begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  // Expected letter in each literal state
  function automatic logic [7:0] literal_char(input state_t s);
    logic [7:0] ch;
    case (s)
      ST_TRUE1:  ch = "r";
      ST_TRUE2:  ch = "u";
      ST_TRUE3:  ch = "e";
      ST_FALSE1: ch = "a";
      ST_FALSE2: ch = "l";
      ST_FALSE3: ch = "s";
      ST_FALSE4: ch = "e";
      ST_NULL1:  ch = "u";
      ST_NULL2:  ch = "l";
      ST_NULL3:  ch = "l";
      default:   ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/json_token_lexer.sv =====
// JSON token lexer.
// Input channel: one transfer per JSON byte (char_byte), or an end-of-stream
// mark (end_of_stream = 1, char_byte ignored), on char_valid / char_ready.
// Result channel: result_valid / result_ready. Each result is either a
// content byte of the current token (decoded string byte or number char)
// or a token end carrying token_kind. last_result marks the final result
// caused by one input byte; a byte may cause zero, one or two results.
// Configuration: cfg_write_en / cfg_write_data set max_token_len (reset 256);
// write it only while the lexer is idle.
// The results of a byte are registered in the result queue on its transfer.
// Throughput: one byte per cycle while char_ready is high. The state
// update for a byte is a single registered step; the rate is set by the
// 4-entry result queue, which drains one result per cycle while result_ready
// is high, so bytes that cause two results hold input once the queue fills.
// char_ready is high while the queue has room for two results; when the
// receiver stalls the queue fills and char_ready drops, nothing is lost.
// Reset (rst, synchronous) returns to the value state, clears the token,
// empties the queue and restores max_token_len to 256.
module json_token_lexer (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_byte,
  input  logic       end_of_stream,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       is_token_end,
  output logic [3:0] token_kind,
  output logic [7:0] content_byte,
  output logic       last_result,
  input  logic       cfg_write_en,
  input  logic [15:0] cfg_write_data
);

  // Lexer state
  jtl_pkg::state_t                  state, state_next;
  logic                             fraction_seen, fraction_seen_next;
  logic [jtl_pkg::LENGTH_BITS-1:0]  token_length, token_length_next;
  logic [7:0]                       hex_low_byte, hex_low_byte_next;
  logic [15:0]                      max_token_len;

  // Result queue
  jtl_pkg::result_t                   fifo [jtl_pkg::FIFO_DEPTH];
  logic [jtl_pkg::FIFO_PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [jtl_pkg::FIFO_CNT_BITS-1:0]  count;

  // Per-byte step
  logic             accept, pop;
  logic             a_valid, b_valid, c_valid;
  jtl_pkg::result_t a_res, b_res, c_res, r0, r1;
  logic [1:0]       push_n;
  logic             reproc, step_ended;
  logic [3:0]       num_kind;
  logic [3:0]       hex_nib;

  assign accept = char_valid && char_ready;
  assign pop    = result_valid && result_ready;

  assign char_ready   = count <= jtl_pkg::FIFO_CNT_BITS'(jtl_pkg::FIFO_DEPTH - 2);
  assign result_valid = count != '0;

  assign is_token_end = fifo[rd_ptr].is_token_end;
  assign token_kind   = fifo[rd_ptr].token_kind;
  assign content_byte = fifo[rd_ptr].content_byte;
  assign last_result  = fifo[rd_ptr].last_result;

  assign num_kind = ((state == jtl_pkg::ST_EXP1) || fraction_seen) ?
                    jtl_pkg::KIND_NUMBER : jtl_pkg::KIND_INT;
  assign hex_nib  = jtl_pkg::hex_nibble(char_byte);

  // Main step: first result (store or finish), then reprocessing of a
  // number terminator, then the too-long check
  always_comb begin
    state_next         = state;
    fraction_seen_next = fraction_seen;
    token_length_next  = token_length;
    hex_low_byte_next  = hex_low_byte;
    a_valid            = 1'b0;
    a_res              = '0;
    b_valid            = 1'b0;
    b_res              = '0;
    c_valid            = 1'b0;
    c_res              = '0;
    reproc             = 1'b0;
    step_ended         = 1'b0;

    if (end_of_stream) begin
      a_valid            = 1'b1;
      a_res.is_token_end = 1'b1;
      a_res.token_kind   = ((state == jtl_pkg::ST_NUMBER) || (state == jtl_pkg::ST_EXP1)) ?
                           num_kind : jtl_pkg::KIND_EOF;
      step_ended         = 1'b1;
    end else begin
      case (state)
        jtl_pkg::ST_VALUE: begin
          a_res.is_token_end = 1'b1;
          step_ended         = 1'b1;
          a_valid            = 1'b1;
          if (char_byte == "{") begin
            a_res.token_kind = jtl_pkg::KIND_LBRACE;
          end else if (char_byte == "}") begin
            a_res.token_kind = jtl_pkg::KIND_RBRACE;
          end else if (char_byte == "[") begin
            a_res.token_kind = jtl_pkg::KIND_LBRACKET;
          end else if (char_byte == "]") begin
            a_res.token_kind = jtl_pkg::KIND_RBRACKET;
          end else if (char_byte == ":") begin
            a_res.token_kind = jtl_pkg::KIND_COLON;
          end else if (char_byte == ",") begin
            a_res.token_kind = jtl_pkg::KIND_COMMA;
          end else if (char_byte == 8'd0) begin
            a_res.token_kind = jtl_pkg::KIND_EOF;
          end else if (!jtl_pkg::is_ws(char_byte) &&
                       ((char_byte < jtl_pkg::CH_SPACE) || (char_byte == jtl_pkg::CH_DEL))) begin
            a_res.token_kind = jtl_pkg::KIND_INVALID;
          end else begin
            // no token end: open a token or skip the byte
            a_valid            = 1'b0;
            step_ended         = 1'b0;
            a_res.is_token_end = 1'b0;
            if (char_byte == "\"") begin
              state_next = jtl_pkg::ST_STRING;
            end else if (char_byte == "t") begin
              state_next = jtl_pkg::ST_TRUE1;
            end else if (char_byte == "f") begin
              state_next = jtl_pkg::ST_FALSE1;
            end else if (char_byte == "n") begin
              state_next = jtl_pkg::ST_NULL1;
            end else if (jtl_pkg::is_digit(char_byte) || (char_byte == "-")) begin
              a_valid            = 1'b1;
              a_res.content_byte = char_byte;
              state_next         = jtl_pkg::ST_NUMBER;
            end
          end
        end
        jtl_pkg::ST_STRING: begin
          a_valid = 1'b1;
          if (char_byte == "\"") begin
            a_res.is_token_end = 1'b1;
            a_res.token_kind   = jtl_pkg::KIND_STRING;
            step_ended         = 1'b1;
          end else if (char_byte == "\\") begin
            a_valid    = 1'b0;
            state_next = jtl_pkg::ST_ESCAPE;
          end else begin
            a_res.content_byte = char_byte;
          end
        end
        jtl_pkg::ST_ESCAPE: begin
          a_valid    = 1'b1;
          state_next = jtl_pkg::ST_STRING;
          if ((char_byte == "\"") || (char_byte == "\\") || (char_byte == "/")) begin
            a_res.content_byte = char_byte;
          end else if (char_byte == "b") begin
            a_res.content_byte = jtl_pkg::CH_BS;
          end else if (char_byte == "f") begin
            a_res.content_byte = jtl_pkg::CH_FF;
          end else if (char_byte == "n") begin
            a_res.content_byte = jtl_pkg::CH_LF;
          end else if (char_byte == "r") begin
            a_res.content_byte = jtl_pkg::CH_CR;
          end else if (char_byte == "t") begin
            a_res.content_byte = jtl_pkg::CH_TAB;
          end else if (char_byte == "u") begin
            a_valid    = 1'b0;
            state_next = jtl_pkg::ST_HEX1;
          end else begin
            a_res.is_token_end = 1'b1;
            a_res.token_kind   = jtl_pkg::KIND_INVALID;
            step_ended         = 1'b1;
          end
        end
        jtl_pkg::ST_HEX1, jtl_pkg::ST_HEX2, jtl_pkg::ST_HEX3, jtl_pkg::ST_HEX4: begin
          if (!jtl_pkg::is_hex(char_byte)) begin
            a_valid            = 1'b1;
            a_res.is_token_end = 1'b1;
            a_res.token_kind   = jtl_pkg::KIND_INVALID;
            step_ended         = 1'b1;
          end else begin
            hex_low_byte_next = {hex_low_byte[3:0], hex_nib};
            if (state == jtl_pkg::ST_HEX4) begin
              a_valid            = 1'b1;
              a_res.content_byte = {hex_low_byte[3:0], hex_nib};
              state_next         = jtl_pkg::ST_STRING;
            end else if (state == jtl_pkg::ST_HEX1) begin
              state_next = jtl_pkg::ST_HEX2;
            end else if (state == jtl_pkg::ST_HEX2) begin
              state_next = jtl_pkg::ST_HEX3;
            end else begin
              state_next = jtl_pkg::ST_HEX4;
            end
          end
        end
        jtl_pkg::ST_NUMBER, jtl_pkg::ST_EXP1: begin
          a_valid = 1'b1;
          if (jtl_pkg::is_term(char_byte)) begin
            // number ends; terminator goes back through the value state
            a_res.is_token_end = 1'b1;
            a_res.token_kind   = num_kind;
            reproc             = 1'b1;
          end else if (jtl_pkg::is_digit(char_byte)) begin
            a_res.content_byte = char_byte;
          end else if ((state == jtl_pkg::ST_NUMBER) &&
                       ((char_byte == "e") || (char_byte == "E"))) begin
            a_res.content_byte = char_byte;
            state_next         = jtl_pkg::ST_EXP;
          end else if ((state == jtl_pkg::ST_NUMBER) && (char_byte == ".") &&
                       !fraction_seen) begin
            a_res.content_byte = char_byte;
            fraction_seen_next = 1'b1;
          end else begin
            a_res.is_token_end = 1'b1;
            a_res.token_kind   = jtl_pkg::KIND_INVALID;
            step_ended         = 1'b1;
          end
        end
        jtl_pkg::ST_EXP: begin
          a_valid = 1'b1;
          if ((char_byte == "-") || (char_byte == "+")) begin
            a_res.content_byte = char_byte;
          end else if (jtl_pkg::is_digit(char_byte)) begin
            a_res.content_byte = char_byte;
            state_next         = jtl_pkg::ST_EXP1;
          end else begin
            a_res.is_token_end = 1'b1;
            a_res.token_kind   = jtl_pkg::KIND_INVALID;
            step_ended         = 1'b1;
          end
        end
        default: begin
          // literal letters of true, false, null
          if (char_byte != jtl_pkg::literal_char(state)) begin
            a_valid            = 1'b1;
            a_res.is_token_end = 1'b1;
            a_res.token_kind   = jtl_pkg::KIND_INVALID;
            step_ended         = 1'b1;
          end else if (state == jtl_pkg::ST_TRUE3) begin
            a_valid            = 1'b1;
            a_res.is_token_end = 1'b1;
            a_res.token_kind   = jtl_pkg::KIND_TRUE;
            step_ended         = 1'b1;
          end else if (state == jtl_pkg::ST_FALSE4) begin
            a_valid            = 1'b1;
            a_res.is_token_end = 1'b1;
            a_res.token_kind   = jtl_pkg::KIND_FALSE;
            step_ended         = 1'b1;
          end else if (state == jtl_pkg::ST_NULL3) begin
            a_valid            = 1'b1;
            a_res.is_token_end = 1'b1;
            a_res.token_kind   = jtl_pkg::KIND_NULL;
            step_ended         = 1'b1;
          end else begin
            state_next = jtl_pkg::state_t'({state[18:0], 1'b0});
          end
        end
      endcase
    end

    // Apply the first result to the token
    if (a_valid && a_res.is_token_end) begin
      state_next         = jtl_pkg::ST_VALUE;
      fraction_seen_next = 1'b0;
      token_length_next  = '0;
    end else if (a_valid) begin
      token_length_next = token_length + jtl_pkg::LENGTH_BITS'(1);
    end

    // Terminator of a number: only , ] } end a token in the value state
    if (reproc) begin
      if (!jtl_pkg::is_ws(char_byte)) begin
        b_valid            = 1'b1;
        b_res.is_token_end = 1'b1;
        step_ended         = 1'b1;
        if (char_byte == ",") begin
          b_res.token_kind = jtl_pkg::KIND_COMMA;
        end else if (char_byte == "]") begin
          b_res.token_kind = jtl_pkg::KIND_RBRACKET;
        end else begin
          b_res.token_kind = jtl_pkg::KIND_RBRACE;
        end
      end
    end

    // Capacity check after a step that did not end a token
    if (!step_ended && (max_token_len != '0) &&
        (32'(token_length_next) >= 32'(max_token_len) - 32'd1)) begin
      c_valid            = 1'b1;
      c_res.is_token_end = 1'b1;
      c_res.token_kind   = jtl_pkg::KIND_TOOLONG;
      state_next         = jtl_pkg::ST_VALUE;
      fraction_seen_next = 1'b0;
      token_length_next  = '0;
    end
  end

  // Order the results: the step's own result first, then B or C
  always_comb begin
    r0     = '0;
    r1     = '0;
    push_n = 2'd0;
    if (a_valid) begin
      r0 = a_res;
      if (b_valid) begin
        r1     = b_res;
        push_n = 2'd2;
      end else if (c_valid) begin
        r1     = c_res;
        push_n = 2'd2;
      end else begin
        push_n = 2'd1;
      end
    end else if (c_valid) begin
      r0     = c_res;
      push_n = 2'd1;
    end
    if (push_n == 2'd2) begin
      r1.last_result = 1'b1;
    end else begin
      r0.last_result = 1'b1;
    end
  end

  // Lexer and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= jtl_pkg::ST_VALUE;
      fraction_seen <= 1'b0;
      token_length  <= '0;
      hex_low_byte  <= '0;
      max_token_len <= jtl_pkg::MAX_LEN_RESET;
    end else begin
      if (accept) begin
        state         <= state_next;
        fraction_seen <= fraction_seen_next;
        token_length  <= token_length_next;
        hex_low_byte  <= hex_low_byte_next;
      end
      if (cfg_write_en) begin
        max_token_len <= cfg_write_data;
      end
    end
  end

  // Result queue payload
  always_ff @(posedge clk) begin
    if (accept && (push_n != 2'd0)) begin
      fifo[wr_ptr] <= r0;
      if (push_n == 2'd2) begin
        fifo[wr_ptr + jtl_pkg::FIFO_PTR_BITS'(1)] <= r1;
      end
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + jtl_pkg::FIFO_PTR_BITS'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + jtl_pkg::FIFO_PTR_BITS'(1);
      end
      count <= count + (accept ? jtl_pkg::FIFO_CNT_BITS'(push_n) : '0)
                     - jtl_pkg::FIFO_CNT_BITS'(pop);
    end
  end

`ifndef SYNTHESIS
  // Queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    count <= jtl_pkg::FIFO_CNT_BITS'(jtl_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // Token ends carry no content byte
  assert property (@(posedge clk) disable iff (rst)
    result_valid && is_token_end |-> content_byte == 8'd0)
    else $error("token end with content byte");

  // Content results carry no kind
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_token_end |-> token_kind == jtl_pkg::KIND_NONE)
    else $error("content result with kind");

  // End of stream always leaves an empty token in the value state
  assert property (@(posedge clk) disable iff (rst)
    accept && end_of_stream |=> state == jtl_pkg::ST_VALUE && token_length == '0)
    else $error("token not closed at end of stream");
`endif

endmodule
